@@ design/ps2dft_pkg.sv @@
// Shared types, codes and frame helpers for the PS/2 device frame transmitter.
package ps2dft_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_MOUSE = 2'd2;

   localparam logic [1:0] HOST_INHIBIT = 2'd0;
   localparam logic [1:0] HOST_IDLE    = 2'd1;

   localparam logic [1:0] PH_READY = 2'd0;
   localparam logic [1:0] PH_LO    = 2'd1;
   localparam logic [1:0] PH_HI    = 2'd2;

   // Line pair: bit 1 is the clock line, bit 0 the data line.
   localparam logic [1:0] LINES_LOW = 2'b00;
   localparam logic [1:0] CLK_ONLY  = 2'b10;

   localparam logic [11:0] HOLD_RESET = 12'd200;
   localparam logic [12:0] TIME_MAX   = 13'd8191;

   typedef struct packed {
      logic       wr_en;
      logic       wr_three;
      logic       rd_en;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } fifo_ctl_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic       room3;
      logic [7:0] head_byte;
   } fifo_sts_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [10:0] frame;
      logic [7:0]  cur;
      logic [12:0] ptime;
      logic        pop;
      logic        stop;
   } eng_type;

   // Start bit, data LSB first, odd parity, stop bit.
   function automatic logic [10:0] make_frame(input logic [7:0] b);
      return {1'b1, ~(^b), b, 1'b0};
   endfunction

   // One phase end, taken only when the elapsed time covers a whole phase.
   function automatic eng_type phase_end(input eng_type s, input logic [11:0] hold,
                                         input logic empty, input logic [7:0] head_byte);
      eng_type r;
      r = s;
      if (!s.stop && (s.ptime >= {1'b0, hold})) begin
         r.ptime = s.ptime - {1'b0, hold};
         if (s.phase == PH_LO) begin
            r.frame = {1'b0, s.frame[10:1]};
            r.phase = PH_HI;
         end else if (s.frame != 11'd0) begin
            r.phase = PH_LO;
         end else if (empty) begin
            r.phase = PH_READY;
            r.ptime = 13'd0;
            r.stop  = 1'b1;
         end else begin
            r.cur   = head_byte;
            r.frame = make_frame(head_byte);
            r.phase = PH_LO;
            r.pop   = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

@@ design/ps2dft_fifo.sv @@
// Byte queue with single and three-byte writes and a read at the head.
module ps2dft_fifo #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ps2dft_pkg::fifo_ctl_type          ctl,
   output ps2dft_pkg::fifo_sts_type          sts,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]   count_next
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [7:0]    mem [FIFO_DEPTH];
   logic [7:0]    head_byte_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] t0, t1, t2, t0_raw, t1_raw, t2_raw;

   // Sums stay below twice the depth, so one compare and subtract wraps them.
   function automatic logic [SW-1:0] wrap(input logic [SW-1:0] v);
      return (v >= SW'(FIFO_DEPTH)) ? v - SW'(FIFO_DEPTH) : v;
   endfunction

   always_comb begin
      t0_raw = SW'(head_ff) + SW'(count_ff);
      t0     = wrap(t0_raw);
      t1_raw = t0 + SW'(1);
      t1     = wrap(t1_raw);
      t2_raw = t0 + SW'(2);
      t2     = wrap(t2_raw);
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.rd_en) begin
         head_in  = (head_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end else if (ctl.wr_en) begin
         count_in = count_ff + (ctl.wr_three ? CW'(3) : CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[t0[AW-1:0]] <= ctl.b0;
         if (ctl.wr_three) begin
            mem[t1[AW-1:0]] <= ctl.b1;
            mem[t2[AW-1:0]] <= ctl.b2;
         end
      end
   end

   // The head byte is registered from the next head position; a write into an empty queue lands at the head.
   always_ff @(posedge clock) begin
      if (ctl.wr_en && (count_ff == '0)) begin
         head_byte_ff <= ctl.b0;
      end else begin
         head_byte_ff <= mem[head_in];
      end
   end

   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CW'(FIFO_DEPTH));
   assign sts.room3     = (count_ff <= CW'(FIFO_DEPTH - 3));
   assign sts.head_byte = head_byte_ff;
   assign count_next    = count_in;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FIFO_DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> (count_ff != '0) && !ctl.wr_en)
      else $error("item taken from an empty queue or with a write");

   a_three_fit: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && ctl.wr_three) |=> count_ff <= CW'(FIFO_DEPTH))
      else $error("report written without three free slots");

endmodule

@@ design/ps2_device_frame_transmitter_unit.sv @@
// Top level of the PS/2 device frame transmitter: input stage, frame engine, result stage.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall operation, host_lines, elapsed, data_byte,
//                                           move_x, move_y, buttons
//   rsp      out        rsp_valid/rsp_stall line_data, line_clock, accepted, fifo_level
//   csr      in         csr_valid/csr_ready hold_time
//
// Each item is held in the input register and then moves to the result register,
// where its result is offered; one item is taken per cycle unless rsp is stalled
// with both registers full. The path that sets the cycle is the tick logic: time
// add with saturation followed by two phase-end compare and subtract steps.
// Synchronous reset clears control state; hold_time returns to 200.
// A stall on rsp holds the result; req stalls only while both registers are full and
// rsp is stalled.
module ps2_device_frame_transmitter_unit #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [1:0]        req_host_lines,
   input  logic [7:0]        req_elapsed,
   input  logic [7:0]        req_data_byte,
   input  logic signed [8:0] req_move_x,
   input  logic signed [8:0] req_move_y,
   input  logic [2:0]        req_buttons,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_line_data,
   output logic              rsp_line_clock,
   output logic              rsp_accepted,
   output logic [5:0]        rsp_fifo_level,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [11:0]       csr_hold_time
);

   localparam int CW = $clog2(FIFO_DEPTH + 1);

   // Input stage
   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_op_ff, in_host_ff;
   logic [7:0]        in_elapsed_ff, in_data_ff;
   logic [8:0]        in_x_ff, in_y_ff;
   logic [2:0]        in_buttons_ff;
   logic              req_take, advance;

   // Frame engine state
   logic [11:0] hold_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [10:0] frame_ff, frame_in;
   logic [7:0]  cur_ff, cur_in;
   logic [12:0] time_ff, time_in;
   logic [1:0]  line_out_ff, line_out_in;
   logic        accepted_in;

   // Result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_data_ff, rsp_clock_ff, rsp_accepted_ff;
   logic [5:0] rsp_level_ff;

   ps2dft_pkg::fifo_ctl_type fifo_ctl;
   ps2dft_pkg::fifo_sts_type fifo_sts;
   logic [CW-1:0]            fifo_count_next;

   ps2dft_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fifo_ctl),
      .sts        (fifo_sts),
      .count_next (fifo_count_next)
   );

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_operation;
         in_host_ff    <= req_host_lines;
         in_elapsed_ff <= req_elapsed;
         in_data_ff    <= req_data_byte;
         in_x_ff       <= req_move_x;
         in_y_ff       <= req_move_y;
         in_buttons_ff <= req_buttons;
      end
   end

   always_comb begin
      ps2dft_pkg::eng_type e0, e1, e2;
      logic [13:0]         sum;
      logic                nothing_to_send;

      phase_in    = phase_ff;
      frame_in    = frame_ff;
      cur_in      = cur_ff;
      time_in     = time_ff;
      line_out_in = line_out_ff;
      accepted_in = 1'b0;
      fifo_ctl    = '0;
      fifo_ctl.b0 = in_data_ff;
      fifo_ctl.b1 = in_x_ff[7:0];
      fifo_ctl.b2 = in_y_ff[7:0];

      e0.phase = phase_ff;
      e0.frame = frame_ff;
      e0.cur   = cur_ff;
      e0.ptime = time_ff;
      e0.pop   = 1'b0;
      e0.stop  = 1'b0;
      nothing_to_send = 1'b0;
      sum = '0;
      e1  = e0;
      e2  = e0;

      if (advance) begin
         case (in_op_ff)
            ps2dft_pkg::OP_TICK: begin
               if (in_host_ff == ps2dft_pkg::HOST_INHIBIT) begin
                  line_out_in = ps2dft_pkg::LINES_LOW;
                  phase_in    = ps2dft_pkg::PH_READY;
               end else if (in_host_ff == ps2dft_pkg::HOST_IDLE) begin
                  // Out of a frame: resend the interrupted byte or start the next one.
                  if (phase_ff != ps2dft_pkg::PH_LO && phase_ff != ps2dft_pkg::PH_HI) begin
                     if (frame_ff == 11'd0 && fifo_sts.empty) begin
                        nothing_to_send = 1'b1;
                     end else begin
                        if (frame_ff == 11'd0) begin
                           e0.cur = fifo_sts.head_byte;
                           e0.pop = 1'b1;
                        end
                        e0.frame = ps2dft_pkg::make_frame(e0.cur);
                        e0.phase = ps2dft_pkg::PH_LO;
                        e0.ptime = 13'd0;
                     end
                  end
                  if (nothing_to_send) begin
                     phase_in    = ps2dft_pkg::PH_READY;
                     line_out_in = ps2dft_pkg::CLK_ONLY;
                  end else begin
                     sum = {1'b0, e0.ptime} + 14'(in_elapsed_ff);
                     e0.ptime = sum[13] ? ps2dft_pkg::TIME_MAX : sum[12:0];
                     e1 = ps2dft_pkg::phase_end(e0, hold_ff, fifo_sts.empty,
                                                fifo_sts.head_byte);
                     e2 = ps2dft_pkg::phase_end(e1, hold_ff, fifo_sts.empty,
                                                fifo_sts.head_byte);
                     phase_in = e2.phase;
                     frame_in = e2.frame;
                     cur_in   = e2.cur;
                     time_in  = e2.ptime;
                     fifo_ctl.rd_en = e2.pop;
                     line_out_in = (e2.phase == ps2dft_pkg::PH_LO) ?
                                   {1'b0, e2.frame[0]} : ps2dft_pkg::CLK_ONLY;
                  end
               end else begin
                  line_out_in = ps2dft_pkg::LINES_LOW;
               end
            end
            ps2dft_pkg::OP_PUSH: begin
               if (!fifo_sts.full) begin
                  fifo_ctl.wr_en = 1'b1;
                  accepted_in    = 1'b1;
               end
            end
            ps2dft_pkg::OP_MOUSE: begin
               if (fifo_sts.room3) begin
                  fifo_ctl.wr_en    = 1'b1;
                  fifo_ctl.wr_three = 1'b1;
                  fifo_ctl.b0       = {2'b00, in_y_ff[8], in_x_ff[8], 1'b1, in_buttons_ff};
                  accepted_in       = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= ps2dft_pkg::HOLD_RESET;
         phase_ff    <= ps2dft_pkg::PH_READY;
         frame_ff    <= '0;
         cur_ff      <= '0;
         time_ff     <= '0;
         line_out_ff <= ps2dft_pkg::LINES_LOW;
      end else begin
         if (csr_valid && csr_ready) begin
            hold_ff <= csr_hold_time;
         end
         phase_ff    <= phase_in;
         frame_ff    <= frame_in;
         cur_ff      <= cur_in;
         time_ff     <= time_in;
         line_out_ff <= line_out_in;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff     <= line_out_in[0];
         rsp_clock_ff    <= line_out_in[1];
         rsp_accepted_ff <= accepted_in;
         rsp_level_ff    <= 6'(fifo_count_next);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_data  = rsp_data_ff;
   assign rsp_line_clock = rsp_clock_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_fifo_level = rsp_level_ff;

   a_lo_has_frame: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ps2dft_pkg::PH_LO |-> frame_ff != 11'd0)
      else $error("low phase with an empty frame");

   a_tick_not_accepted: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == ps2dft_pkg::OP_TICK) |=> !rsp_accepted_ff)
      else $error("tick item reported as queued");

   a_inhibit_lines: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == ps2dft_pkg::OP_TICK &&
       in_host_ff == ps2dft_pkg::HOST_INHIBIT)
      |=> phase_ff == ps2dft_pkg::PH_READY && line_out_ff == ps2dft_pkg::LINES_LOW)
      else $error("inhibit did not drop the lines");

   a_pop_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      fifo_ctl.rd_en |-> advance && in_op_ff == ps2dft_pkg::OP_TICK &&
                         in_host_ff == ps2dft_pkg::HOST_IDLE)
      else $error("byte taken from the queue outside an idle tick");

endmodule
